[rtl/clug_pkg.sv]
// ----------------------------------------------------------------------------
// clug_pkg: shared constants for the combined LCG uniform generator
// Moduli, Schrage factors, reciprocal constants for the constant divisions
// and the combinational Schrage step used by the state update.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package clug_pkg;

	typedef logic [14:0] state_t;

	localparam logic FN_DRAW   = 1'b0;
	localparam logic FN_RESEED = 1'b1;

	localparam state_t MOD_A = 15'd30269;
	localparam state_t MOD_B = 15'd30307;
	localparam state_t MOD_C = 15'd30323;

	localparam state_t INIT_A = 15'd11;
	localparam state_t INIT_B = 15'd23;
	localparam state_t INIT_C = 15'd137;

	localparam logic [7:0] DIV_A = 8'd177;
	localparam logic [7:0] DIV_B = 8'd176;
	localparam logic [7:0] DIV_C = 8'd178;

	localparam logic [7:0] MUL_A = 8'd171;
	localparam logic [7:0] MUL_B = 8'd172;
	localparam logic [7:0] MUL_C = 8'd170;

	localparam logic [7:0] REM_A = 8'd2;
	localparam logic [7:0] REM_B = 8'd35;
	localparam logic [7:0] REM_C = 8'd63;

	localparam logic [7:0] SEED_DIV = 8'd178;
	localparam logic [7:0] SEED_MUL = 8'd170;
	localparam state_t     SEED_OFS = 15'd137;

	// ceil(2^23 / d): exact quotient for any 15-bit dividend
	localparam int unsigned QSH = 23;
	localparam logic [31:0] RCP_QA_W = ((32'd1 << QSH) + 32'd176) / 32'd177;
	localparam logic [31:0] RCP_QB_W = ((32'd1 << QSH) + 32'd175) / 32'd176;
	localparam logic [31:0] RCP_QC_W = ((32'd1 << QSH) + 32'd177) / 32'd178;
	localparam logic [15:0] RCP_QA = RCP_QA_W[15:0];
	localparam logic [15:0] RCP_QB = RCP_QB_W[15:0];
	localparam logic [15:0] RCP_QC = RCP_QC_W[15:0];

	// ceil(2^29 / 178): exact quotient for the folded 21-bit seed
	localparam int unsigned SSH = 29;
	localparam logic [31:0] RCP_SEED_W = ((32'd1 << SSH) + 32'd177) / 32'd178;
	localparam logic [21:0] RCP_SEED = RCP_SEED_W[21:0];

	// ceil(2^62 / m): floor(s * 2^32 / m) = (s * R) >> 30 for s below m
	localparam int unsigned TSH = 30;
	localparam logic [63:0] TRM_A = ((64'd1 << 62) + 64'd30268) / 64'd30269;
	localparam logic [63:0] TRM_B = ((64'd1 << 62) + 64'd30306) / 64'd30307;
	localparam logic [63:0] TRM_C = ((64'd1 << 62) + 64'd30322) / 64'd30323;
	localparam int unsigned PPW = 24;
	localparam logic [PPW-1:0] TRM_A_HI = TRM_A[2*PPW-1:PPW];
	localparam logic [PPW-1:0] TRM_A_LO = TRM_A[PPW-1:0];
	localparam logic [PPW-1:0] TRM_B_HI = TRM_B[2*PPW-1:PPW];
	localparam logic [PPW-1:0] TRM_B_LO = TRM_B[PPW-1:0];
	localparam logic [PPW-1:0] TRM_C_HI = TRM_C[2*PPW-1:PPW];
	localparam logic [PPW-1:0] TRM_C_LO = TRM_C[PPW-1:0];

	typedef logic [PPW+14:0] pprod_t;

	// mult*(s mod d) - rm*(s div d), wrapped into [0, md)
	function automatic state_t schrage_step(
		input state_t     s,
		input logic [7:0] d,
		input logic [15:0] rcp,
		input logic [7:0] mult,
		input logic [7:0] rm,
		input state_t     md
	);
		logic [30:0] prod;
		logic [7:0]  q;
		logic [14:0] r;
		logic [17:0] t;
		prod = 31'(s) * 31'(rcp);
		q    = prod[30:23];
		r    = s - 15'(16'(q) * 16'(d));
		t    = 18'(mult) * 18'(r[7:0]) - 18'(rm) * 18'(q);
		if (t[17]) begin
			t = t + 18'(md);
		end
		return t[14:0];
	endfunction

endpackage

`default_nettype wire

[rtl/combined_lcg_uniform_generator.sv]
// ----------------------------------------------------------------------------
// combined_lcg_uniform_generator: Wichmann-Hill uniform random source
// Takes one command per cycle while cmd_stall is low; a draw command gives a
// 0.32 fixed-point fraction in [0,1), a reseed command (func high) sets the
// third generator from seed and gives no result. The three 15-bit states
// advance through a combinational Schrage step each into registers, which
// sets the sustained rate of one command per clock when nothing stalls. The
// fraction is formed in three further stages: reciprocal partial products,
// per-term combination, and the final sum modulo 2^32. When a result is held
// by res_stall, the whole pipeline holds and cmd_stall rises.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module combined_lcg_uniform_generator (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cmd_valid,
	output logic             cmd_stall,
	input  wire logic        func,
	input  wire logic [30:0] seed,
	output logic             res_valid,
	input  wire logic        res_stall,
	output logic [31:0]      fraction
);

	clug_pkg::state_t gen_a_q, gen_b_q, gen_c_q;
	clug_pkg::state_t nxt_a, nxt_b, nxt_c, seed_c;

	logic        adv;
	logic        vld_s1, vld_s2, vld_s3, vld_s4;
	clug_pkg::state_t st_a_s1, st_b_s1, st_c_s1;
	clug_pkg::pprod_t pa_hi_s2, pa_lo_s2, pb_hi_s2, pb_lo_s2, pc_hi_s2, pc_lo_s2;
	logic [31:0] ta_s3, tb_s3, tc_s3;
	logic [31:0] frac_s4;

	logic [20:0] seed_fold;
	logic [42:0] seed_prod;
	logic [13:0] seed_quo;
	logic [20:0] seed_rem;
	logic [63:0] full_a, full_b, full_c;

	assign adv       = !(vld_s4 && res_stall);
	assign cmd_stall = !adv;
	assign res_valid = vld_s4;
	assign fraction  = frac_s4;

	assign nxt_a = clug_pkg::schrage_step(gen_a_q, clug_pkg::DIV_A, clug_pkg::RCP_QA,
		clug_pkg::MUL_A, clug_pkg::REM_A, clug_pkg::MOD_A);
	assign nxt_b = clug_pkg::schrage_step(gen_b_q, clug_pkg::DIV_B, clug_pkg::RCP_QB,
		clug_pkg::MUL_B, clug_pkg::REM_B, clug_pkg::MOD_B);
	assign nxt_c = clug_pkg::schrage_step(gen_c_q, clug_pkg::DIV_C, clug_pkg::RCP_QC,
		clug_pkg::MUL_C, clug_pkg::REM_C, clug_pkg::MOD_C);

	// fold with 2^16 mod 178 = 32, then divide the narrow value by reciprocal
	always_comb begin
		seed_fold = 21'({seed[30:16], 5'b0}) + 21'(seed[15:0]);
		seed_prod = 43'(seed_fold) * 43'(clug_pkg::RCP_SEED);
		seed_quo  = seed_prod[42:29];
		seed_rem  = seed_fold - 21'(22'(seed_quo) * 22'(clug_pkg::SEED_DIV));
		seed_c    = 15'(16'(clug_pkg::SEED_MUL) * 16'(seed_rem[7:0]))
			+ clug_pkg::SEED_OFS;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_a_q <= clug_pkg::INIT_A;
			gen_b_q <= clug_pkg::INIT_B;
			gen_c_q <= clug_pkg::INIT_C;
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
		end else if (adv) begin
			vld_s1 <= cmd_valid && (func == clug_pkg::FN_DRAW);
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			if (cmd_valid) begin
				if (func == clug_pkg::FN_RESEED) begin
					gen_c_q <= seed_c;
				end else begin
					gen_a_q <= nxt_a;
					gen_b_q <= nxt_b;
					gen_c_q <= nxt_c;
				end
			end
		end
	end

	always_comb begin
		full_a = 64'({pa_hi_s2, 24'b0}) + 64'(pa_lo_s2);
		full_b = 64'({pb_hi_s2, 24'b0}) + 64'(pb_lo_s2);
		full_c = 64'({pc_hi_s2, 24'b0}) + 64'(pc_lo_s2);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			st_a_s1  <= nxt_a;
			st_b_s1  <= nxt_b;
			st_c_s1  <= nxt_c;
			pa_hi_s2 <= clug_pkg::pprod_t'(st_a_s1) * clug_pkg::pprod_t'(clug_pkg::TRM_A_HI);
			pa_lo_s2 <= clug_pkg::pprod_t'(st_a_s1) * clug_pkg::pprod_t'(clug_pkg::TRM_A_LO);
			pb_hi_s2 <= clug_pkg::pprod_t'(st_b_s1) * clug_pkg::pprod_t'(clug_pkg::TRM_B_HI);
			pb_lo_s2 <= clug_pkg::pprod_t'(st_b_s1) * clug_pkg::pprod_t'(clug_pkg::TRM_B_LO);
			pc_hi_s2 <= clug_pkg::pprod_t'(st_c_s1) * clug_pkg::pprod_t'(clug_pkg::TRM_C_HI);
			pc_lo_s2 <= clug_pkg::pprod_t'(st_c_s1) * clug_pkg::pprod_t'(clug_pkg::TRM_C_LO);
			ta_s3    <= full_a[61:30];
			tb_s3    <= full_b[61:30];
			tc_s3    <= full_c[61:30];
			frac_s4  <= ta_s3 + tb_s3 + tc_s3;
		end
	end

	a_state_range: assert property (@(posedge clk) disable iff (!arst_n)
		(gen_a_q < clug_pkg::MOD_A) && (gen_b_q < clug_pkg::MOD_B)
		&& (gen_c_q < clug_pkg::MOD_C))
		else $error("generator state out of range");

	a_reseed_keeps_ab: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && !cmd_stall && (func == clug_pkg::FN_RESEED))
		|=> ($stable(gen_a_q) && $stable(gen_b_q)))
		else $error("reseed changed first or second generator");

	a_draw_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && !cmd_stall && (func == clug_pkg::FN_DRAW)) |=> vld_s1)
		else $error("draw transfer did not enter pipeline");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_stall |-> (res_valid && res_stall))
		else $error("command stalled without a held result");

endmodule

`default_nettype wire
